// ----- rtl/ghdr_pkg.sv -----
// Shared types, constants and tables for the gyro heading dead reckoning block.
package ghdr_pkg;

    // Field widths of the input and result beats.
    localparam int GYRO_W     = 14;
    localparam int SPEED_W    = 16;
    localparam int DT_W       = 16;
    localparam int POS_W      = 32;
    localparam int HEAD_W     = 16;
    localparam int DEADBAND_W = 10;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 10'd128;

    // Raw gyro thresholds, Q10.4: 400 and 500 scaled by 16.
    localparam logic [GYRO_W-1:0] GYRO_WRAP = 14'd6400;
    localparam logic [GYRO_W-1:0] GYRO_ZERO = 14'd8000;

    // Rate divider: numerator up to 6400 * 16, divided by five one bit per cycle.
    localparam int RATE_DIV  = 5;
    localparam int DIV_W     = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int REM_W     = $clog2(RATE_DIV);

    // Heading arithmetic, Q3.13.
    localparam int PI_Q13      = 25736;
    localparam int TWO_PI_Q13  = 51472;
    localparam int MOD_STEPS   = 5;
    localparam int MOD_SPAN    = TWO_PI_Q13 << (MOD_STEPS - 1);
    localparam int MOD_W       = 21;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS + 1);
    localparam int HEAD_SUM_W  = 24;

    // CORDIC in rotation mode: angle Q.20, vector Q.30.
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int ITER_W       = $clog2(ATAN_ENTRIES);
    localparam int ANGLE_W      = 23;
    localparam int CORDIC_W     = 32;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [ANGLE_W-1:0]  PI_Z        = 23'sd3294208;
    localparam logic signed [ANGLE_W-1:0]  HALF_PI_Z   = 23'sd1647104;

    // Bit-serial multiplier size.
    localparam int MUL_W     = 32;
    localparam int MUL_CNT_W = $clog2(MUL_W);

    typedef struct packed {
        logic [GYRO_W-1:0]         gyro_raw;
        logic signed [SPEED_W-1:0] speed;
        logic [DT_W-1:0]           time_step;
    } in_beat_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [HEAD_W-1:0] heading;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } state_t;

    // Arctangent of 2^-i, rounded in Q.20.
    function automatic logic [19:0] atan_q20(input logic [ITER_W-1:0] idx);
        logic [19:0] val;
        case (idx)
            5'd0:    val = 20'd823550;
            5'd1:    val = 20'd486170;
            5'd2:    val = 20'd256879;
            5'd3:    val = 20'd130396;
            5'd4:    val = 20'd65451;
            5'd5:    val = 20'd32757;
            5'd6:    val = 20'd16383;
            5'd7:    val = 20'd8192;
            5'd8:    val = 20'd4096;
            5'd9:    val = 20'd2048;
            5'd10:   val = 20'd1024;
            5'd11:   val = 20'd512;
            5'd12:   val = 20'd256;
            5'd13:   val = 20'd128;
            5'd14:   val = 20'd64;
            5'd15:   val = 20'd32;
            5'd16:   val = 20'd16;
            5'd17:   val = 20'd8;
            5'd18:   val = 20'd4;
            5'd19:   val = 20'd2;
            5'd20:   val = 20'd1;
            default: val = 20'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/gyro_heading_dead_reckoning.sv -----
// Gyro heading dead reckoning: one position and heading update per tick beat.
//
// Each accepted tick beat turns the raw gyro reading into a turn rate, moves the
// position along the old heading by speed times time step, and advances the
// heading by rate times time step, wrapped into [-pi, pi). A tick occupies the
// block through acceptance, the bit-serial divide by five of the gyro reading
// (the CORDIC runs its 16 rotations alongside), the first pass of the two
// bit-serial 32 x 32 multipliers (rate and speed times time step), the second
// pass (speed times time step times cosine and sine, with the heading wrap done
// meanwhile), and the commit of the state and the load of the output register,
// which waits until an earlier result is taken. The next tick can be accepted
// in the same cycle as the result appears, even while the result still waits on
// m_ready. The deadband register may be written while idle.
module gyro_heading_dead_reckoning (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  ghdr_pkg::in_beat_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output ghdr_pkg::out_beat_t                   m_data,
    input  logic                                  cfg_wr_en,
    input  logic [ghdr_pkg::DEADBAND_W-1:0]       cfg_wr_data
);
    import ghdr_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [DEADBAND_W-1:0]     deadband_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic [DT_W-1:0]           dt_reg;

    // Rate divider.
    logic [DIV_W-1:0]     n_reg;
    logic [REM_W-1:0]     rem_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_W-1:0]     n_start;
    logic                 neg_start;
    logic [GYRO_W-1:0]    gyro_back;
    logic [REM_W:0]       rem_ext;
    logic                 q_bit;
    logic [REM_W-1:0]     rem_step;

    // Heading wrap.
    logic [MOD_W-1:0]     mod_reg;
    logic [MOD_W-1:0]     sub_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;

    logic signed [POS_W-1:0]  acc_x_reg;
    logic signed [POS_W-1:0]  acc_y_reg;
    logic signed [HEAD_W-1:0] acc_head_reg;

    out_beat_t out_reg;
    logic      out_valid_reg;

    // Control.
    logic accept;
    logic div_done;
    logic mul1_start;
    logic mul2_start;
    logic finish;
    logic out_load;

    logic signed [CORDIC_W-1:0] cos_q30;
    logic signed [CORDIC_W-1:0] sin_q30;
    logic                       cordic_busy;

    logic signed [MUL_W-1:0]     mul_a_x;
    logic signed [MUL_W-1:0]     mul_a_y;
    logic        [MUL_W-1:0]     mul_b;
    logic                        mul_busy_x;
    logic                        mul_busy_y;
    logic signed [2*MUL_W-1:0]   prod_x;
    logic signed [2*MUL_W-1:0]   prod_y;

    logic                        rate_zero;
    logic signed [DIV_W:0]       rate_s;
    logic signed [HEAD_SUM_W-1:0] head_sum;
    logic signed [HEAD_SUM_W-1:0] head_adj;
    logic signed [POS_W:0]       dx;
    logic signed [POS_W:0]       dy;
    logic signed [POS_W:0]       sum_x;
    logic signed [POS_W:0]       sum_y;
    logic signed [POS_W-1:0]     new_x;
    logic signed [POS_W-1:0]     new_y;
    logic signed [HEAD_W-1:0]    new_head;

    ghdr_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .angle   (acc_head_reg),
        .busy    (cordic_busy),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    ghdr_smul u_mul_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul1_start | mul2_start),
        .a       (mul_a_x),
        .b       (mul_b),
        .busy    (mul_busy_x),
        .product (prod_x)
    );

    ghdr_smul u_mul_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul1_start | mul2_start),
        .a       (mul_a_y),
        .b       (mul_b),
        .busy    (mul_busy_y),
        .product (prod_y)
    );

    // Control strobes of the sequencer.
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        accept     = s_ready && s_valid;
        div_done   = (div_cnt_reg == DIV_CNT_W'(DIV_W));
        mul1_start = (state_reg == ST_DIV) && div_done && !cordic_busy;
        mul2_start = (state_reg == ST_MUL1) && !mul_busy_x && !mul_busy_y;
        finish     = (state_reg == ST_MUL2) && !mul_busy_x && !mul_busy_y;
        out_load   = (state_reg == ST_OUT) && (!out_valid_reg || m_ready);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (mul1_start) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (mul2_start) begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (finish) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Divider numerator: readings above the wrap point count backward from the zero point.
    always_comb begin
        n_start   = '0;
        neg_start = 1'b0;
        gyro_back = GYRO_ZERO - s_data.gyro_raw;
        if (s_data.gyro_raw >= GYRO_ZERO) begin
            n_start = '0;
        end else if (s_data.gyro_raw > GYRO_WRAP) begin
            n_start   = {gyro_back[DIV_W-5:0], 4'b0};
            neg_start = 1'b1;
        end else begin
            n_start = {s_data.gyro_raw[DIV_W-5:0], 4'b0};
        end
    end

    // One quotient bit per cycle of the restoring divide by five.
    always_comb begin
        rem_ext = {rem_reg, n_reg[DIV_W-1]};
        q_bit   = (rem_ext >= (REM_W + 1)'(RATE_DIV));
        if (q_bit) begin
            rem_step = REM_W'(rem_ext - (REM_W + 1)'(RATE_DIV));
        end else begin
            rem_step = rem_ext[REM_W-1:0];
        end
    end

    // Signed turn rate after the deadband, and the multiplier operands of both passes.
    always_comb begin
        rate_zero = (n_reg <= DIV_W'(deadband_reg));
        if (rate_zero) begin
            rate_s = '0;
        end else if (neg_reg) begin
            rate_s = -$signed({1'b0, n_reg});
        end else begin
            rate_s = $signed({1'b0, n_reg});
        end
        if (mul2_start) begin
            mul_a_x = cos_q30;
            mul_a_y = sin_q30;
            mul_b   = prod_y[MUL_W-1:0];
        end else begin
            mul_a_x = {{(MUL_W - DIV_W - 1){rate_s[DIV_W]}}, rate_s};
            mul_a_y = {{(MUL_W - SPEED_W){speed_reg[SPEED_W-1]}}, speed_reg};
            mul_b   = {(MUL_W - DT_W)'(0), dt_reg};
        end
    end

    // Heading plus rounded delta, offset by pi and made non-negative for the wrap.
    always_comb begin
        head_sum = {{(HEAD_SUM_W - HEAD_W){acc_head_reg[HEAD_W-1]}}, acc_head_reg}
                 + {{(HEAD_SUM_W - 21){prod_x[31]}}, prod_x[31:11]}
                 + {(HEAD_SUM_W - 1)'(0), prod_x[10]}
                 + HEAD_SUM_W'(PI_Q13);
        if (head_sum[HEAD_SUM_W-1]) begin
            head_adj = head_sum + HEAD_SUM_W'(MOD_SPAN);
        end else begin
            head_adj = head_sum;
        end
    end

    // Rounded position steps and saturating accumulation.
    always_comb begin
        dx    = {{(POS_W + 1 - 22){prod_x[63]}}, prod_x[63:42]} + {POS_W'(0), prod_x[41]};
        dy    = {{(POS_W + 1 - 22){prod_y[63]}}, prod_y[63:42]} + {POS_W'(0), prod_y[41]};
        sum_x = {acc_x_reg[POS_W-1], acc_x_reg} + dx;
        sum_y = {acc_y_reg[POS_W-1], acc_y_reg} + dy;
        if (sum_x[POS_W] != sum_x[POS_W-1]) begin
            new_x = sum_x[POS_W] ? {1'b1, (POS_W - 1)'(0)} : {1'b0, {(POS_W - 1){1'b1}}};
        end else begin
            new_x = sum_x[POS_W-1:0];
        end
        if (sum_y[POS_W] != sum_y[POS_W-1]) begin
            new_y = sum_y[POS_W] ? {1'b1, (POS_W - 1)'(0)} : {1'b0, {(POS_W - 1){1'b1}}};
        end else begin
            new_y = sum_y[POS_W-1:0];
        end
        new_head = mod_reg[HEAD_W-1:0] - HEAD_W'(PI_Q13);
    end

    // Deadband register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= DEADBAND_RESET;
        end else if (cfg_wr_en) begin
            deadband_reg <= cfg_wr_data;
        end
    end

    // Sequencer, counters, output beat valid and accumulated state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            mod_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                div_cnt_reg <= '0;
            end else if ((state_reg == ST_DIV) && !div_done) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (mul2_start) begin
                mod_cnt_reg <= '0;
            end else if ((state_reg == ST_MUL2) && (mod_cnt_reg != MOD_CNT_W'(MOD_STEPS))) begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            if (finish) begin
                acc_x_reg    <= new_x;
                acc_y_reg    <= new_y;
                acc_head_reg <= new_head;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            speed_reg <= s_data.speed;
            dt_reg    <= s_data.time_step;
            n_reg     <= n_start;
            neg_reg   <= neg_start;
            rem_reg   <= '0;
        end else if ((state_reg == ST_DIV) && !div_done) begin
            n_reg   <= {n_reg[DIV_W-2:0], q_bit};
            rem_reg <= rem_step;
        end
        // Heading wrap: compare and subtract 2*pi scaled down one power of two per cycle.
        if (mul2_start) begin
            mod_reg <= head_adj[MOD_W-1:0];
            sub_reg <= MOD_W'(MOD_SPAN);
        end else if ((state_reg == ST_MUL2) && (mod_cnt_reg != MOD_CNT_W'(MOD_STEPS))) begin
            if (mod_reg >= sub_reg) begin
                mod_reg <= mod_reg - sub_reg;
            end
            sub_reg <= sub_reg >> 1;
        end
        if (out_load) begin
            out_reg.pos_x   <= acc_x_reg;
            out_reg.pos_y   <= acc_y_reg;
            out_reg.heading <= acc_head_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- rtl/ghdr_smul.sv -----
// Bit-serial signed 32 x 32 multiplier, one multiplier bit per cycle.
module ghdr_smul (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [ghdr_pkg::MUL_W-1:0]      a,
    input  logic        [ghdr_pkg::MUL_W-1:0]      b,
    output logic                                   busy,
    output logic signed [2*ghdr_pkg::MUL_W-1:0]    product
);
    import ghdr_pkg::*;

    logic signed [MUL_W-1:0] a_reg;
    logic signed [MUL_W-1:0] hi_reg;
    logic        [MUL_W-1:0] lo_reg;
    logic [MUL_CNT_W-1:0]    cnt_reg;
    logic                    busy_reg;

    logic                    last;
    logic signed [MUL_W:0]   addend;
    logic signed [MUL_W:0]   sum;

    // Add the multiplicand for the current multiplier bit; the top bit weighs negative.
    always_comb begin
        last = (cnt_reg == MUL_CNT_W'(MUL_W - 1));
        if (!lo_reg[0]) begin
            addend = '0;
        end else if (last) begin
            addend = -{a_reg[MUL_W-1], a_reg};
        end else begin
            addend = {a_reg[MUL_W-1], a_reg};
        end
        sum = {hi_reg[MUL_W-1], hi_reg} + addend;
    end

    // Sequencing of the shift-add passes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (last) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // The product shifts right; low bits replace the consumed multiplier bits.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum[MUL_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_W-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ----- rtl/ghdr_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine of a Q3.13 heading.
module ghdr_cordic (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [ghdr_pkg::HEAD_W-1:0]    angle,
    output logic                                  busy,
    output logic signed [ghdr_pkg::CORDIC_W-1:0]  cos_q30,
    output logic signed [ghdr_pkg::CORDIC_W-1:0]  sin_q30
);
    import ghdr_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [ANGLE_W-1:0]  z_reg;
    logic                       neg_reg;
    logic [ITER_W-1:0]          it_reg;
    logic                       busy_reg;

    logic signed [ANGLE_W-1:0]  z_start;
    logic signed [ANGLE_W-1:0]  z_fold;
    logic                       neg_fold;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [ANGLE_W-1:0]  at;
    logic                       last;

    // Fold the angle into [-pi/2, pi/2]; the half turn negates both results.
    always_comb begin
        z_start  = {angle, 7'b0};
        z_fold   = z_start;
        neg_fold = 1'b0;
        if (z_start > HALF_PI_Z) begin
            z_fold   = z_start - PI_Z;
            neg_fold = 1'b1;
        end else if (z_start < -HALF_PI_Z) begin
            z_fold   = z_start + PI_Z;
            neg_fold = 1'b1;
        end
    end

    always_comb begin
        xs   = x_reg >>> it_reg;
        ys   = y_reg >>> it_reg;
        at   = {3'b0, atan_q20(it_reg)};
        last = (it_reg == ITER_W'(CORDIC_ITERS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            it_reg   <= '0;
        end else if (busy_reg) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                it_reg <= it_reg + 1'b1;
            end
        end
    end

    // One micro-rotation per cycle toward zero residual angle.
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= z_fold;
            neg_reg <= neg_fold;
        end else if (busy_reg) begin
            if (!z_reg[ANGLE_W-1]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign busy    = busy_reg;
    assign cos_q30 = neg_reg ? -x_reg : x_reg;
    assign sin_q30 = neg_reg ? -y_reg : y_reg;

endmodule

// ----- rtl/ghdr_checker.sv -----
// Port-level checks of the dead reckoning block, bound to its top level.
module ghdr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input ghdr_pkg::out_beat_t              m_data
);
    import ghdr_pkg::*;

    // A result beat that is held back keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Reported heading always lies in [-pi, pi).
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.heading >= -HEAD_W'(PI_Q13)) && (m_data.heading < HEAD_W'(PI_Q13)))
        else $error("heading outside the wrap range");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // Ticks are worked one at a time, so ready drops after an accepted tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second tick accepted while one is in progress");

endmodule

bind gyro_heading_dead_reckoning ghdr_checker u_ghdr_checker (.*);

// ----- dv/ghdr_pose_checker.sv -----
`timescale 1ns / 1ps
// Pose checker for the gyro heading dead reckoning block: predicts each result beat and compares.
module ghdr_pose_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  ghdr_pkg::in_beat_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ghdr_pkg::out_beat_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [ghdr_pkg::DEADBAND_W-1:0] cfg_wr_data,
    output int                              fail_count,
    output int                              pending
);

    // Heading is Q3.13 with pi taken as 25736; the rotation angle is Q.20.
    localparam longint HEAD_PI        = 25736;
    localparam longint HEAD_TWO_PI    = 51472;
    localparam longint ANGLE_PI       = HEAD_PI * 128;
    localparam longint ANGLE_HALF_PI  = 12868 * 128;
    localparam longint UNIT_GAIN      = 652032874;
    localparam int     ROTATION_STEPS = 16;
    localparam int     ARCTAN_ENTRIES = 24;
    localparam int     ROTATIONS      = (ROTATION_STEPS < ARCTAN_ENTRIES) ?
                                        ROTATION_STEPS : ARCTAN_ENTRIES;
    localparam longint POS_MAX        = 64'sd2147483647;
    localparam longint POS_MIN        = -64'sd2147483648;
    localparam longint GYRO_WRAP_RAW  = 6400;
    localparam longint GYRO_NULL_RAW  = 8000;
    localparam int     DEADBAND_AT_RESET = 128;

    longint              pos_x_acc;
    longint              pos_y_acc;
    longint              head_acc;
    logic [9:0]          deadband;
    ghdr_pkg::out_beat_t pending_poses[$];
    ghdr_pkg::out_beat_t want;
    int                  errors = 0;

    // Arctangent of 2^-i in Q.20, rounded.
    function automatic longint arctan_q20(input int i);
        case (i)
            0:  return 823550;
            1:  return 486170;
            2:  return 256879;
            3:  return 130396;
            4:  return 65451;
            5:  return 32757;
            6:  return 16383;
            7:  return 8192;
            8:  return 4096;
            9:  return 2048;
            10: return 1024;
            11: return 512;
            12: return 256;
            13: return 128;
            14: return 64;
            15: return 32;
            16: return 16;
            17: return 8;
            18: return 4;
            19: return 2;
            20: return 1;
            default: return 0;
        endcase
    endfunction

    // Rotation-mode CORDIC: cosine and sine of a Q3.13 heading, both Q.30.
    function automatic void unit_vector(input longint head, output longint cos_q30,
                                        output longint sin_q30);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit     flip;
        int     i;
        z = head * 128;
        x = UNIT_GAIN;
        y = 0;
        flip = 1'b0;
        // Fold the angle into the right half plane; that negates both results.
        if (z > ANGLE_HALF_PI) begin
            z = z - ANGLE_PI;
            flip = 1'b1;
        end else if (z < -ANGLE_HALF_PI) begin
            z = z + ANGLE_PI;
            flip = 1'b1;
        end
        for (i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q20(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q20(i);
            end
        end
        cos_q30 = flip ? -x : x;
        sin_q30 = flip ? -y : y;
    endfunction

    // Turn rate in Q7.8 from the raw reading, after the deadband.
    function automatic longint turn_rate(input longint raw);
        longint rate;
        longint mag;
        if (raw >= GYRO_NULL_RAW) begin
            rate = 0;
        end else if (raw > GYRO_WRAP_RAW) begin
            rate = -(((GYRO_NULL_RAW - raw) * 16) / 5);
        end else begin
            rate = (raw * 16) / 5;
        end
        mag = (rate < 0) ? -rate : rate;
        if (mag <= longint'(deadband)) begin
            rate = 0;
        end
        return rate;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX) begin
            return POS_MAX;
        end
        if (v < POS_MIN) begin
            return POS_MIN;
        end
        return v;
    endfunction

    // Advance the pose by one tick: move along the old heading, then turn.
    function automatic ghdr_pkg::out_beat_t advance_pose(input ghdr_pkg::in_beat_t tick);
        longint              speed;
        longint              dt;
        longint              rate;
        longint              c;
        longint              s;
        longint              h;
        ghdr_pkg::out_beat_t pose;
        speed = longint'($signed(tick.speed));
        dt = longint'(tick.time_step);
        rate = turn_rate(longint'(tick.gyro_raw));
        unit_vector(head_acc, c, s);
        pos_x_acc = clamp_pos(pos_x_acc + ((speed * c * dt + (64'sd1 <<< 41)) >>> 42));
        pos_y_acc = clamp_pos(pos_y_acc + ((speed * s * dt + (64'sd1 <<< 41)) >>> 42));
        h = (head_acc + ((rate * dt + 64'sd1024) >>> 11) + HEAD_PI) % HEAD_TWO_PI;
        if (h < 0) begin
            h = h + HEAD_TWO_PI;
        end
        head_acc = h - HEAD_PI;
        pose.pos_x = pos_x_acc[31:0];
        pose.pos_y = pos_y_acc[31:0];
        pose.heading = head_acc[15:0];
        return pose;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        end
    endtask

    // Result beats are checked before a tick beat of the same edge is predicted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_acc = 0;
            pos_y_acc = 0;
            head_acc = 0;
            deadband = 10'(DEADBAND_AT_RESET);
            pending_poses.delete();
        end else begin
            if (cfg_wr_en) begin
                deadband = cfg_wr_data;
            end
            if ($isunknown(m_valid)) begin
                errors++;
                $error("m_valid mismatch: expected 0 or 1, got %b", m_valid);
            end else if (m_valid && m_ready) begin
                if (pending_poses.size() == 0) begin
                    errors++;
                    $error("result beat with no tick waiting: pos_x %0d pos_y %0d heading %0d",
                           m_data.pos_x, m_data.pos_y, m_data.heading);
                end else begin
                    want = pending_poses.pop_front();
                    check_field("pos_x", want.pos_x, m_data.pos_x);
                    check_field("pos_y", want.pos_y, m_data.pos_y);
                    check_field("heading", want.heading, m_data.heading);
                end
            end
            if (s_valid && s_ready) begin
                pending_poses.push_back(advance_pose(s_data));
            end
        end
        fail_count <= errors;
        pending <= pending_poses.size();
    end

endmodule

// ----- dv/gyro_heading_dead_reckoning_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the gyro heading dead reckoning block: stimulus, idling and verdict.
module gyro_heading_dead_reckoning_test;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_TICKS   = 440;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    ghdr_pkg::in_beat_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    ghdr_pkg::out_beat_t             m_data;
    logic                            cfg_wr_en;
    logic [ghdr_pkg::DEADBAND_W-1:0] cfg_wr_data;
    int                              fail_count;
    int                              pending;
    int                              idle_pct = 0;
    int                              stall_pct = 0;
    int                              quiet_cycles = 0;

    gyro_heading_dead_reckoning uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ghdr_pose_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side stalls at random with the current percentage.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: give up after a long stretch with no beat on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("gyro_heading_dead_reckoning test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic ghdr_pkg::in_beat_t make_tick(input int gyro, input int speed,
                                                     input int dt);
        ghdr_pkg::in_beat_t t;
        t.gyro_raw = 14'(gyro);
        t.speed = 16'(speed);
        t.time_step = 16'(dt);
        return t;
    endfunction

    // Random tick: readings weighted toward each rate region and its borders.
    function automatic ghdr_pkg::in_beat_t random_tick();
        ghdr_pkg::in_beat_t t;
        case ($urandom_range(7))
            0:       t.gyro_raw = 14'($urandom_range(16383));
            1, 2:    t.gyro_raw = 14'($urandom_range(6400));
            3, 4:    t.gyro_raw = 14'($urandom_range(7999, 6401));
            5:       t.gyro_raw = 14'($urandom_range(16383, 8000));
            default: begin
                case ($urandom_range(5))
                    0:       t.gyro_raw = 14'd0;
                    1:       t.gyro_raw = 14'd6400;
                    2:       t.gyro_raw = 14'd6401;
                    3:       t.gyro_raw = 14'd7999;
                    4:       t.gyro_raw = 14'd8000;
                    default: t.gyro_raw = 14'd16383;
                endcase
            end
        endcase
        if ($urandom_range(7) == 0) begin
            t.speed = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end else begin
            t.speed = 16'($urandom);
        end
        case ($urandom_range(7))
            0:       t.time_step = 16'd0;
            1:       t.time_step = 16'hffff;
            2:       t.time_step = 16'($urandom_range(255));
            default: t.time_step = 16'($urandom);
        endcase
        return t;
    endfunction

    // Offer one tick beat, after a random idle gap, and hold it until accepted.
    task automatic send_tick(input ghdr_pkg::in_beat_t t);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Stop sending and wait until every predicted pose has come back.
    task automatic drain_poses();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_deadband(input int band);
        drain_poses();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= 10'(band);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int phase;
        int band;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A turn of exactly pi from zero lands on -pi; the next ticks move with cos = -1.
        send_tick(make_tick(5120, 16384, 3217));
        send_tick(make_tick(0, 32767, 65535));
        send_tick(make_tick(8000, -32768, 65535));
        // Zero time step: nothing moves even with a large rate.
        send_tick(make_tick(16383, 0, 0));
        send_tick(make_tick(6401, 100, 0));
        // A small rate inside the deadband, then rates at the default deadband and just above it.
        send_tick(make_tick(7999, -1, 1));
        send_tick(make_tick(40, 12345, 65535));
        send_tick(make_tick(41, -12345, 1));
        // Another turn of pi brings the heading back to zero.
        send_tick(make_tick(5120, 16384, 3217));

        // Extremes of the fields.
        send_tick(make_tick(6400, 32767, 65535));
        send_tick(make_tick(6401, -32768, 65535));
        send_tick(make_tick(16383, -32768, 1));
        send_tick(make_tick(8000, 1, 65535));
        send_tick(make_tick(0, 0, 0));

        // Random phases, each with its own deadband and idling pattern.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    band = 0;
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    band = 1023;
                    idle_pct = 71;
                    stall_pct = 0;
                end
                2: begin
                    band = $urandom_range(1023);
                    idle_pct = 0;
                    stall_pct = 71;
                end
                default: begin
                    band = $urandom_range(1023);
                    idle_pct = 31;
                    stall_pct = 31;
                end
            endcase
            set_deadband(band);
            repeat (PHASE_TICKS) send_tick(random_tick());
        end

        drain_poses();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("gyro_heading_dead_reckoning test passed");
        end else begin
            $display("gyro_heading_dead_reckoning test failed");
        end
        $finish;
    end

endmodule
